>>> rtl/pdp_pkg.sv
// Shared types, constants and fixed-point helpers of the pinhole distortion projector.
// No dependencies; the files that use it refer to it by scoped names.
package pdp_pkg;

  typedef logic signed [63:0] q_t;

  localparam q_t LimitQ = 64'sh1FFF_FFFF_FFFF_FFFF;

  localparam int DivBits  = 32;
  localparam int FracBits = 28;
  localparam int DistLat  = 28;
  localparam int ProjLat  = 4;

  localparam logic [3:0] TermsReset = 4'd4;
  localparam logic [3:0] TermsK3    = 4'd5;
  localparam logic [3:0] TermsK4    = 4'd6;
  localparam logic [3:0] TermsK5    = 4'd7;
  localparam logic [3:0] TermsK6    = 4'd8;

  typedef enum logic [2:0] {
    REG_FOCAL,
    REG_CENTER,
    REG_RADIAL1,
    REG_TANGENT,
    REG_RADIAL2,
    REG_EXTRA,
    REG_TERMS
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] k4;
    logic signed [31:0] k5;
    logic signed [31:0] k6;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic [3:0]         terms;
  } coef_t;

  function automatic q_t sext32(logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // Saturating add; both operands lie within +-LimitQ.
  function automatic q_t qadd(q_t a, q_t b);
    q_t s;
    s = a + b;
    if (s > LimitQ) return LimitQ;
    if (s < -LimitQ) return -LimitQ;
    return s;
  endfunction

endpackage

>>> rtl/pdp_if.sv
// Handshake channels of the pinhole distortion projector: point, pixel and register write.
// Depends on nothing.
interface pdp_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface pdp_pixel_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pixel_u;
  logic signed [31:0] pixel_v;
  logic               zero_depth;
  logic               saturated;
  modport source (output valid, pixel_u, pixel_v, zero_depth, saturated, input ready);
  modport sink (input valid, pixel_u, pixel_v, zero_depth, saturated, output ready);
endinterface

interface pdp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [63:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> rtl/pdp_qmul.sv
// Four-stage exact 64x64 signed fixed-point multiplier with truncating shift and clip.
// Depends on pdp_pkg.
module pdp_qmul (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          sh24_i,
  input  pdp_pkg::q_t   a_i,
  input  pdp_pkg::q_t   b_i,
  output pdp_pkg::q_t   p_o
);

  logic [63:0]  ua_q, ub_q;
  logic         neg1_q, neg2_q, neg3_q;
  logic [63:0]  ll_q, lh_q, hl_q, hh_q;
  logic [127:0] prod_q;
  pdp_pkg::q_t  p_q;
  logic [127:0] wide;
  logic [63:0]  mag;

  always_comb begin
    wide = sh24_i ? (prod_q >> 24) : (prod_q >> 28);
    mag  = (|wide[127:61]) ? 64'(pdp_pkg::LimitQ) : wide[63:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q   <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      ub_q   <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      neg1_q <= a_i[63] ^ b_i[63];
      ll_q   <= 64'(ua_q[31:0]) * 64'(ub_q[31:0]);
      lh_q   <= 64'(ua_q[31:0]) * 64'(ub_q[63:32]);
      hl_q   <= 64'(ua_q[63:32]) * 64'(ub_q[31:0]);
      hh_q   <= 64'(ua_q[63:32]) * 64'(ub_q[63:32]);
      neg2_q <= neg1_q;
      prod_q <= {hh_q, 64'b0} + {32'b0, lh_q, 32'b0} + {32'b0, hl_q, 32'b0} + {64'b0, ll_q};
      neg3_q <= neg2_q;
      p_q    <= neg3_q ? -$signed(mag) : $signed(mag);
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/pdp_divider.sv
// Pipelined restoring divider: normalizes x and y by depth into saturated Q4.28.
// Depends on pdp_pkg.
module pdp_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic signed [31:0] z_i,
  output logic               valid_o,
  output logic               zero_o,
  output logic signed [31:0] xn_o,
  output logic signed [31:0] yn_o
);

  localparam int NumBits = 32 - pdp_pkg::FracBits;

  logic [pdp_pkg::DivBits:0] v_q;
  logic                      zero_q [pdp_pkg::DivBits+1];
  logic                      ovfx_q [pdp_pkg::DivBits+1];
  logic                      ovfy_q [pdp_pkg::DivBits+1];
  logic                      negx_q [pdp_pkg::DivBits+1];
  logic                      negy_q [pdp_pkg::DivBits+1];
  logic [31:0]               d_q    [pdp_pkg::DivBits+1];
  logic [31:0]               rx_q   [pdp_pkg::DivBits+1];
  logic [31:0]               ry_q   [pdp_pkg::DivBits+1];
  logic [31:0]               qx_q   [pdp_pkg::DivBits+1];
  logic [31:0]               qy_q   [pdp_pkg::DivBits+1];
  logic [NumBits-1:0]        nx_q   [pdp_pkg::DivBits+1];
  logic [NumBits-1:0]        ny_q   [pdp_pkg::DivBits+1];
  logic [31:0]               rx_d   [pdp_pkg::DivBits+1];
  logic [31:0]               ry_d   [pdp_pkg::DivBits+1];
  logic                      gx_d   [pdp_pkg::DivBits+1];
  logic                      gy_d   [pdp_pkg::DivBits+1];

  logic        valid_q, zero_q_out;
  logic signed [31:0] xn_q, yn_q;
  logic [31:0] ax, ay, az;

  assign ax = x_i[31] ? 32'(-x_i) : 32'(x_i);
  assign ay = y_i[31] ? 32'(-y_i) : 32'(y_i);
  assign az = z_i[31] ? 32'(-z_i) : 32'(z_i);

  assign rx_d[0] = '0;
  assign ry_d[0] = '0;
  assign gx_d[0] = 1'b0;
  assign gy_d[0] = 1'b0;

  // One quotient bit per stage; only the top numerator bits are non-zero.
  for (genvar s = 1; s <= pdp_pkg::DivBits; s++) begin : g_step
    logic        nbx, nby;
    logic [32:0] tx, ty;
    if (pdp_pkg::DivBits - s >= pdp_pkg::FracBits) begin : g_nb
      assign nbx = nx_q[s-1][pdp_pkg::DivBits-s-pdp_pkg::FracBits];
      assign nby = ny_q[s-1][pdp_pkg::DivBits-s-pdp_pkg::FracBits];
    end else begin : g_nz
      assign nbx = 1'b0;
      assign nby = 1'b0;
    end
    assign tx      = {rx_q[s-1], nbx};
    assign ty      = {ry_q[s-1], nby};
    assign gx_d[s] = tx >= {1'b0, d_q[s-1]};
    assign gy_d[s] = ty >= {1'b0, d_q[s-1]};
    assign rx_d[s] = gx_d[s] ? 32'(tx - {1'b0, d_q[s-1]}) : tx[31:0];
    assign ry_d[s] = gy_d[s] ? 32'(ty - {1'b0, d_q[s-1]}) : ty[31:0];
  end

  function automatic logic signed [31:0] finish(logic [31:0] q, logic ovf, logic neg);
    if (ovf || q[31]) return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return neg ? -$signed(q) : $signed(q);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[pdp_pkg::DivBits-1:0], valid_i};
      valid_q <= v_q[pdp_pkg::DivBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0]    <= az;
      rx_q[0]   <= 32'(ax[31:NumBits]);
      ry_q[0]   <= 32'(ay[31:NumBits]);
      nx_q[0]   <= ax[NumBits-1:0];
      ny_q[0]   <= ay[NumBits-1:0];
      ovfx_q[0] <= 32'(ax[31:NumBits]) >= az;
      ovfy_q[0] <= 32'(ay[31:NumBits]) >= az;
      negx_q[0] <= x_i[31] ^ z_i[31];
      negy_q[0] <= y_i[31] ^ z_i[31];
      zero_q[0] <= (z_i == '0);
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      for (int s = 1; s <= pdp_pkg::DivBits; s++) begin
        d_q[s]    <= d_q[s-1];
        nx_q[s]   <= nx_q[s-1];
        ny_q[s]   <= ny_q[s-1];
        ovfx_q[s] <= ovfx_q[s-1];
        ovfy_q[s] <= ovfy_q[s-1];
        negx_q[s] <= negx_q[s-1];
        negy_q[s] <= negy_q[s-1];
        zero_q[s] <= zero_q[s-1];
        rx_q[s]   <= rx_d[s];
        ry_q[s]   <= ry_d[s];
        qx_q[s]   <= {qx_q[s-1][30:0], gx_d[s]};
        qy_q[s]   <= {qy_q[s-1][30:0], gy_d[s]};
      end
      xn_q <= finish(qx_q[pdp_pkg::DivBits], ovfx_q[pdp_pkg::DivBits],
                     negx_q[pdp_pkg::DivBits]);
      yn_q <= finish(qy_q[pdp_pkg::DivBits], ovfy_q[pdp_pkg::DivBits],
                     negy_q[pdp_pkg::DivBits]);
      zero_q_out <= zero_q[pdp_pkg::DivBits];
    end
  end

  assign valid_o = valid_q;
  assign zero_o  = zero_q_out;
  assign xn_o    = xn_q;
  assign yn_o    = yn_q;

endmodule

>>> rtl/pdp_distort.sv
// Distortion datapath: radial, tangential and per-axis terms on normalized coordinates.
// Depends on pdp_pkg and pdp_qmul.
module pdp_distort (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic               zero_i,
  input  logic signed [31:0] xn_i,
  input  logic signed [31:0] yn_i,
  input  pdp_pkg::coef_t     coef_i,
  output logic               valid_o,
  output logic               zero_o,
  output pdp_pkg::q_t        xd_o,
  output pdp_pkg::q_t        yd_o
);

  pdp_pkg::q_t x0, y0;
  pdp_pkg::q_t mx2, my2, mxy;
  pdp_pkg::q_t r2_q, dxy_q, ax_q, ay_q;
  pdp_pkg::q_t r4, kr1, k5r2, k6r2, tx1, tx2, ty1, ty2;
  pdp_pkg::q_t r6, kr2, e5, e6, r8, kr3, kr4, xr, yr;
  pdp_pkg::q_t s12_q, s123_q, rad_q, xa_q, ya_q, xd_q, yd_q;
  pdp_pkg::q_t xl_q   [26];
  pdp_pkg::q_t yl_q   [26];
  pdp_pkg::q_t r2l_q  [8];
  pdp_pkg::q_t kr1l_q [4];
  pdp_pkg::q_t s12l_q [3];
  pdp_pkg::q_t s123l_q[3];
  pdp_pkg::q_t tx1l_q [17];
  pdp_pkg::q_t ty1l_q [17];
  pdp_pkg::q_t tx2l_q [18];
  pdp_pkg::q_t ty2l_q [18];
  pdp_pkg::q_t e5l_q  [14];
  pdp_pkg::q_t e6l_q  [14];
  logic [pdp_pkg::DistLat-1:0] vl_q, zl_q;
  logic en3, en4, en5, en6, en7, en8;

  assign x0 = pdp_pkg::sext32(xn_i);
  assign y0 = pdp_pkg::sext32(yn_i);

  assign en3 = coef_i.terms >= pdp_pkg::TermsK3;
  assign en4 = coef_i.terms >= pdp_pkg::TermsK4;
  assign en5 = coef_i.terms >= pdp_pkg::TermsK5;
  assign en6 = coef_i.terms >= pdp_pkg::TermsK6;
  assign en7 = en5;
  assign en8 = en6;

  // Squares and cross product.
  pdp_qmul u_mx2 (.clk_i, .en_i, .sh24_i(1'b0), .a_i(x0), .b_i(x0), .p_o(mx2));
  pdp_qmul u_my2 (.clk_i, .en_i, .sh24_i(1'b0), .a_i(y0), .b_i(y0), .p_o(my2));
  pdp_qmul u_mxy (.clk_i, .en_i, .sh24_i(1'b0), .a_i(x0), .b_i(y0), .p_o(mxy));

  // Powers of r2 and first coefficient products.
  pdp_qmul u_r4 (.clk_i, .en_i, .sh24_i(1'b0), .a_i(r2_q), .b_i(r2_q), .p_o(r4));
  pdp_qmul u_kr1 (.clk_i, .en_i, .sh24_i(1'b1), .a_i(pdp_pkg::sext32(coef_i.k1)),
                  .b_i(r2_q), .p_o(kr1));
  pdp_qmul u_k5r2 (.clk_i, .en_i, .sh24_i(1'b1), .a_i(pdp_pkg::sext32(coef_i.k5)),
                   .b_i(r2_q), .p_o(k5r2));
  pdp_qmul u_k6r2 (.clk_i, .en_i, .sh24_i(1'b1), .a_i(pdp_pkg::sext32(coef_i.k6)),
                   .b_i(r2_q), .p_o(k6r2));
  pdp_qmul u_tx1 (.clk_i, .en_i, .sh24_i(1'b1), .a_i(pdp_pkg::sext32(coef_i.p1)),
                  .b_i(dxy_q), .p_o(tx1));
  pdp_qmul u_tx2 (.clk_i, .en_i, .sh24_i(1'b1), .a_i(pdp_pkg::sext32(coef_i.p2)),
                  .b_i(ax_q), .p_o(tx2));
  pdp_qmul u_ty1 (.clk_i, .en_i, .sh24_i(1'b1), .a_i(pdp_pkg::sext32(coef_i.p1)),
                  .b_i(ay_q), .p_o(ty1));
  pdp_qmul u_ty2 (.clk_i, .en_i, .sh24_i(1'b1), .a_i(pdp_pkg::sext32(coef_i.p2)),
                  .b_i(dxy_q), .p_o(ty2));

  pdp_qmul u_r6 (.clk_i, .en_i, .sh24_i(1'b0), .a_i(r4), .b_i(r2l_q[3]), .p_o(r6));
  pdp_qmul u_kr2 (.clk_i, .en_i, .sh24_i(1'b1), .a_i(pdp_pkg::sext32(coef_i.k2)),
                  .b_i(r4), .p_o(kr2));
  pdp_qmul u_e5 (.clk_i, .en_i, .sh24_i(1'b0), .a_i(k5r2), .b_i(xl_q[8]), .p_o(e5));
  pdp_qmul u_e6 (.clk_i, .en_i, .sh24_i(1'b0), .a_i(k6r2), .b_i(yl_q[8]), .p_o(e6));

  pdp_qmul u_r8 (.clk_i, .en_i, .sh24_i(1'b0), .a_i(r6), .b_i(r2l_q[7]), .p_o(r8));
  pdp_qmul u_kr3 (.clk_i, .en_i, .sh24_i(1'b1), .a_i(pdp_pkg::sext32(coef_i.k3)),
                  .b_i(r6), .p_o(kr3));
  pdp_qmul u_kr4 (.clk_i, .en_i, .sh24_i(1'b1), .a_i(pdp_pkg::sext32(coef_i.k4)),
                  .b_i(r8), .p_o(kr4));

  pdp_qmul u_xr (.clk_i, .en_i, .sh24_i(1'b0), .a_i(xl_q[21]), .b_i(rad_q), .p_o(xr));
  pdp_qmul u_yr (.clk_i, .en_i, .sh24_i(1'b0), .a_i(yl_q[21]), .b_i(rad_q), .p_o(yr));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= '0;
    end else if (en_i) begin
      vl_q <= {vl_q[pdp_pkg::DistLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zl_q <= {zl_q[pdp_pkg::DistLat-2:0], zero_i};
      xl_q[0] <= x0;
      yl_q[0] <= y0;
      for (int i = 1; i < 26; i++) begin
        xl_q[i] <= xl_q[i-1];
        yl_q[i] <= yl_q[i-1];
      end
      r2_q  <= pdp_pkg::qadd(mx2, my2);
      dxy_q <= pdp_pkg::qadd(mxy, mxy);
      ax_q  <= pdp_pkg::qadd(pdp_pkg::qadd(mx2, my2), pdp_pkg::qadd(mx2, mx2));
      ay_q  <= pdp_pkg::qadd(pdp_pkg::qadd(mx2, my2), pdp_pkg::qadd(my2, my2));
      r2l_q[0] <= r2_q;
      for (int i = 1; i < 8; i++) r2l_q[i] <= r2l_q[i-1];
      kr1l_q[0] <= kr1;
      for (int i = 1; i < 4; i++) kr1l_q[i] <= kr1l_q[i-1];
      tx1l_q[0] <= tx1;
      ty1l_q[0] <= ty1;
      for (int i = 1; i < 17; i++) begin
        tx1l_q[i] <= tx1l_q[i-1];
        ty1l_q[i] <= ty1l_q[i-1];
      end
      tx2l_q[0] <= tx2;
      ty2l_q[0] <= ty2;
      for (int i = 1; i < 18; i++) begin
        tx2l_q[i] <= tx2l_q[i-1];
        ty2l_q[i] <= ty2l_q[i-1];
      end
      e5l_q[0] <= e5;
      e6l_q[0] <= e6;
      for (int i = 1; i < 14; i++) begin
        e5l_q[i] <= e5l_q[i-1];
        e6l_q[i] <= e6l_q[i-1];
      end
      // Radial sum, accumulated in the order k1, k2, k3, k4.
      s12_q <= pdp_pkg::qadd(kr1l_q[3], kr2);
      s12l_q[0] <= s12_q;
      for (int i = 1; i < 3; i++) s12l_q[i] <= s12l_q[i-1];
      s123_q <= en3 ? pdp_pkg::qadd(s12l_q[2], kr3) : s12l_q[2];
      s123l_q[0] <= s123_q;
      for (int i = 1; i < 3; i++) s123l_q[i] <= s123l_q[i-1];
      rad_q <= en4 ? pdp_pkg::qadd(s123l_q[2], kr4) : s123l_q[2];
      xa_q <= pdp_pkg::qadd(pdp_pkg::qadd(xl_q[25], xr), tx1l_q[16]);
      ya_q <= pdp_pkg::qadd(pdp_pkg::qadd(yl_q[25], yr), ty1l_q[16]);
      xd_q <= pdp_pkg::qadd(pdp_pkg::qadd(xa_q, tx2l_q[17]), en7 ? e5l_q[13] : '0);
      yd_q <= pdp_pkg::qadd(pdp_pkg::qadd(ya_q, ty2l_q[17]), en8 ? e6l_q[13] : '0);
    end
  end

  assign valid_o = vl_q[pdp_pkg::DistLat-1];
  assign zero_o  = zl_q[pdp_pkg::DistLat-1];
  assign xd_o    = xd_q;
  assign yd_o    = yd_q;

endmodule

>>> rtl/pinhole_distortion_projector_unit.sv
// Pinhole projector with radial, tangential and per-axis lens distortion, in fixed point.
// Depends on pdp_pkg, pdp_if, pdp_divider, pdp_distort and pdp_qmul.
//
// One point item (signed Q16.16 x, y, z) enters per clock while point_i.ready is high
// and leaves as one pixel item (signed Q16.16 u, v, saturated). The depth division is a
// restoring divider: an input register, 32 stages of one quotient bit each and a result
// register; the distortion terms run through 28 stages of four-stage 64x64 multipliers
// built from 32x32 partial products; scaling by the focal lengths and adding the centre
// follow, ahead of the output register. The whole pipeline advances together; a skid
// register behind the output register lets one more item through while the sink holds
// off, after which point_i.ready drops until the sink takes a pixel. Registers are
// written through cfg_i, which is always ready, and must only be written while no item
// is in flight. A zero depth gives zero pixels with zero_depth set.
module pinhole_distortion_projector_unit (
  input logic              clk_i,
  input logic              rst_ni,
  pdp_point_if.sink        point_i,
  pdp_pixel_if.source      pixel_o,
  pdp_cfg_if.sink          cfg_i
);

  typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               zero_depth;
    logic               saturated;
  } pixel_t;

  // Configuration registers.
  logic [63:0] focal_q, center_q, radial1_q, tangent_q, radial2_q, extra_q;
  logic [3:0]  terms_q;
  pdp_pkg::coef_t coef;

  // Pipeline control and stage links.
  logic               en;
  logic               div_valid, div_zero;
  logic signed [31:0] xn, yn;
  logic               dist_valid, dist_zero;
  pdp_pkg::q_t        xd, yd, pu, pv;
  logic [pdp_pkg::ProjLat-1:0] pv_q, pz_q;
  logic               push;
  pixel_t             res, out_q, skid_q;
  logic               out_v_q, skid_v_q, out_load;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q   <= '0;
      center_q  <= '0;
      radial1_q <= '0;
      tangent_q <= '0;
      radial2_q <= '0;
      extra_q   <= '0;
      terms_q   <= pdp_pkg::TermsReset;
    end else if (cfg_i.valid) begin
      case (pdp_pkg::cfg_reg_e'(cfg_i.reg_index))
        pdp_pkg::REG_FOCAL:   focal_q   <= cfg_i.wdata;
        pdp_pkg::REG_CENTER:  center_q  <= cfg_i.wdata;
        pdp_pkg::REG_RADIAL1: radial1_q <= cfg_i.wdata;
        pdp_pkg::REG_TANGENT: tangent_q <= cfg_i.wdata;
        pdp_pkg::REG_RADIAL2: radial2_q <= cfg_i.wdata;
        pdp_pkg::REG_EXTRA:   extra_q   <= cfg_i.wdata;
        pdp_pkg::REG_TERMS:   terms_q   <= cfg_i.wdata[3:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  always_comb begin
    coef.k1    = radial1_q[63:32];
    coef.k2    = radial1_q[31:0];
    coef.p1    = tangent_q[63:32];
    coef.p2    = tangent_q[31:0];
    coef.k3    = radial2_q[63:32];
    coef.k4    = radial2_q[31:0];
    coef.k5    = extra_q[63:32];
    coef.k6    = extra_q[31:0];
    coef.terms = terms_q;
  end

  // Advance the whole pipeline unless the skid register already holds an item.
  assign en            = !skid_v_q;
  assign point_i.ready = en;

  pdp_divider u_divider (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i (point_i.valid),
    .x_i     (point_i.point_x),
    .y_i     (point_i.point_y),
    .z_i     (point_i.point_z),
    .valid_o (div_valid),
    .zero_o  (div_zero),
    .xn_o    (xn),
    .yn_o    (yn)
  );

  pdp_distort u_distort (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i (div_valid),
    .zero_i  (div_zero),
    .xn_i    (xn),
    .yn_i    (yn),
    .coef_i  (coef),
    .valid_o (dist_valid),
    .zero_o  (dist_zero),
    .xd_o    (xd),
    .yd_o    (yd)
  );

  // Scale by the focal lengths (unsigned, zero-extended).
  pdp_qmul u_scale_u (.clk_i, .en_i(en), .sh24_i(1'b0),
                      .a_i({32'b0, focal_q[63:32]}), .b_i(xd), .p_o(pu));
  pdp_qmul u_scale_v (.clk_i, .en_i(en), .sh24_i(1'b0),
                      .a_i({32'b0, focal_q[31:0]}), .b_i(yd), .p_o(pv));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[pdp_pkg::ProjLat-2:0], dist_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) pz_q <= {pz_q[pdp_pkg::ProjLat-2:0], dist_zero};
  end

  // Add the centre, clip to 32 bits and flag the clip; force zero for zero depth.
  always_comb begin
    pdp_pkg::q_t su, sv;
    logic        cu, cv;
    su = pdp_pkg::qadd(pu, {32'b0, center_q[63:32]});
    sv = pdp_pkg::qadd(pv, {32'b0, center_q[31:0]});
    cu = (su > 64'sd2147483647) || (su < -64'sd2147483648);
    cv = (sv > 64'sd2147483647) || (sv < -64'sd2147483648);
    if (pz_q[pdp_pkg::ProjLat-1]) begin
      res.pixel_u    = '0;
      res.pixel_v    = '0;
      res.zero_depth = 1'b1;
      res.saturated  = 1'b0;
    end else begin
      res.pixel_u    = cu ? (su[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : su[31:0];
      res.pixel_v    = cv ? (sv[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : sv[31:0];
      res.zero_depth = 1'b0;
      res.saturated  = cu | cv;
    end
  end

  // Output register with one skid entry behind it.
  assign push     = en && pv_q[pdp_pkg::ProjLat-1];
  assign out_load = !out_v_q || pixel_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_load) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign pixel_o.valid      = out_v_q;
  assign pixel_o.pixel_u    = out_q.pixel_u;
  assign pixel_o.pixel_v    = out_q.pixel_v;
  assign pixel_o.zero_depth = out_q.zero_depth;
  assign pixel_o.saturated  = out_q.saturated;

`ifndef SYNTHESIS
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without an output item");

  a_stall_to_skid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !pixel_o.ready && push) |=> skid_v_q)
    else $error("item pushed during output stall was not caught by the skid entry");

  a_zero_depth_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_o.valid && pixel_o.zero_depth) |->
      (!pixel_o.saturated && pixel_o.pixel_u == '0 && pixel_o.pixel_v == '0))
    else $error("zero depth item carries non-zero pixels or a clip flag");

  a_freeze_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(pv_q))
    else $error("pipeline moved while frozen");
`endif

endmodule

>>> dv/pinhole_distortion_projector_unit_test.sv
// Self-checking test of the pinhole distortion projector: random and directed points
// under several register settings, checked against an in-bench fixed-point predictor.
// Depends on pdp_pkg, pdp_if and the projector RTL.
module pinhole_distortion_projector_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic               zd;
    logic               sat;
  } pixel_t;

  localparam longint unsigned CycleLimit = 2000000;
  localparam int Drain = 120;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pdp_point_if point_ch();
  pdp_pixel_if pixel_ch();
  pdp_cfg_if   cfg_ch();

  pinhole_distortion_projector_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .point_i (point_ch.sink),
    .pixel_o (pixel_ch.source),
    .cfg_i   (cfg_ch.sink)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the block's registers
  logic [63:0] focal_q, centre_q, radial1_q, tangent_q, radial2_q, extra_q;
  logic [3:0]  terms_q;

  point_t point_queue[$];
  pixel_t pixel_queue[$];
  int     send_idle_pct, recv_idle_pct;
  int     mismatches;
  longint unsigned cycles;
  bit     cfg_busy;
  bit     in_taken;
  logic [2:0]  cfg_idx_pend;
  logic [63:0] cfg_data_pend;

  // Exact product, magnitude truncated then clipped to the Q.28 bound
  function automatic pdp_pkg::q_t mul_shift(pdp_pkg::q_t a, pdp_pkg::q_t b, int sh);
    logic [127:0] ua, ub, pr, m;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? 128'(-a) : 128'(a);
    ub = b < 0 ? 128'(-b) : 128'(b);
    pr = ua * ub;
    m = pr >> sh;
    if (m > 128'(pdp_pkg::LimitQ)) m = 128'(pdp_pkg::LimitQ);
    return neg ? -pdp_pkg::q_t'(m[63:0]) : pdp_pkg::q_t'(m[63:0]);
  endfunction

  function automatic pdp_pkg::q_t norm_coord(pdp_pkg::q_t c, pdp_pkg::q_t z);
    logic signed [95:0] q;
    q = (96'(c) <<< 28) / 96'(z);
    if (q > 96'sd2147483647) q = 96'sd2147483647;
    if (q < -96'sd2147483648) q = -96'sd2147483648;
    return pdp_pkg::q_t'(q);
  endfunction

  // Project one point with the current register shadow
  function automatic pixel_t project_point(point_t p);
    pixel_t r;
    pdp_pkg::q_t xn, yn, mx2, my2, mxy, r2, r4, r6, r8, rad, xd, yd, pu, pv;
    pdp_pkg::q_t k1, k2, k3, k4, k5, k6, p1, p2;
    int n;
    r = '0;
    if (p.z == 0) begin
      r.zd = 1'b1;
      return r;
    end
    n = terms_q;
    k1 = pdp_pkg::sext32(radial1_q[63:32]);  k2 = pdp_pkg::sext32(radial1_q[31:0]);
    p1 = pdp_pkg::sext32(tangent_q[63:32]);  p2 = pdp_pkg::sext32(tangent_q[31:0]);
    k3 = pdp_pkg::sext32(radial2_q[63:32]);  k4 = pdp_pkg::sext32(radial2_q[31:0]);
    k5 = pdp_pkg::sext32(extra_q[63:32]);    k6 = pdp_pkg::sext32(extra_q[31:0]);
    xn = norm_coord(pdp_pkg::sext32(p.x), pdp_pkg::sext32(p.z));
    yn = norm_coord(pdp_pkg::sext32(p.y), pdp_pkg::sext32(p.z));
    mx2 = mul_shift(xn, xn, 28);
    my2 = mul_shift(yn, yn, 28);
    mxy = mul_shift(xn, yn, 28);
    r2 = pdp_pkg::qadd(mx2, my2);
    r4 = mul_shift(r2, r2, 28);
    r6 = mul_shift(r4, r2, 28);
    r8 = mul_shift(r6, r2, 28);
    rad = pdp_pkg::qadd(mul_shift(k1, r2, 24), mul_shift(k2, r4, 24));
    if (n >= pdp_pkg::TermsK3) rad = pdp_pkg::qadd(rad, mul_shift(k3, r6, 24));
    if (n >= pdp_pkg::TermsK4) rad = pdp_pkg::qadd(rad, mul_shift(k4, r8, 24));
    xd = pdp_pkg::qadd(xn, mul_shift(xn, rad, 28));
    xd = pdp_pkg::qadd(xd, mul_shift(p1, pdp_pkg::qadd(mxy, mxy), 24));
    xd = pdp_pkg::qadd(xd, mul_shift(p2, pdp_pkg::qadd(r2, pdp_pkg::qadd(mx2, mx2)), 24));
    yd = pdp_pkg::qadd(yn, mul_shift(yn, rad, 28));
    yd = pdp_pkg::qadd(yd, mul_shift(p1, pdp_pkg::qadd(r2, pdp_pkg::qadd(my2, my2)), 24));
    yd = pdp_pkg::qadd(yd, mul_shift(p2, pdp_pkg::qadd(mxy, mxy), 24));
    if (n >= pdp_pkg::TermsK5)
      xd = pdp_pkg::qadd(xd, mul_shift(mul_shift(k5, r2, 24), xn, 28));
    if (n >= pdp_pkg::TermsK6)
      yd = pdp_pkg::qadd(yd, mul_shift(mul_shift(k6, r2, 24), yn, 28));
    // Focal lengths and centres are unsigned halves
    pu = pdp_pkg::qadd(mul_shift(pdp_pkg::q_t'({32'd0, focal_q[63:32]}), xd, 28),
                       pdp_pkg::q_t'({32'd0, centre_q[63:32]}));
    pv = pdp_pkg::qadd(mul_shift(pdp_pkg::q_t'({32'd0, focal_q[31:0]}), yd, 28),
                       pdp_pkg::q_t'({32'd0, centre_q[31:0]}));
    if (pu > 64'sd2147483647) begin pu = 64'sd2147483647; r.sat = 1'b1; end
    if (pu < -64'sd2147483648) begin pu = -64'sd2147483648; r.sat = 1'b1; end
    if (pv > 64'sd2147483647) begin pv = 64'sd2147483647; r.sat = 1'b1; end
    if (pv < -64'sd2147483648) begin pv = -64'sd2147483648; r.sat = 1'b1; end
    r.u = pu[31:0];
    r.v = pv[31:0];
    return r;
  endfunction

  // Driver: advance one point per handshake, idle at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!point_ch.valid || in_taken) begin
        in_taken = 1'b0;
        if (point_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          point_ch.valid   <= 1'b1;
          point_ch.point_x <= point_queue[0].x;
          point_ch.point_y <= point_queue[0].y;
          point_ch.point_z <= point_queue[0].z;
        end else begin
          point_ch.valid <= 1'b0;
        end
      end
      pixel_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (cfg_busy) begin
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= cfg_idx_pend;
        cfg_ch.wdata     <= cfg_data_pend;
      end else begin
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on acceptance, check on delivery
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (point_ch.valid && point_ch.ready) begin
        pixel_queue.push_back(project_point(point_queue.pop_front()));
        in_taken = 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready && cfg_busy) begin
        cfg_busy = 1'b0;
      end
      if (pixel_ch.valid && pixel_ch.ready) begin
        got = {pixel_ch.pixel_u, pixel_ch.pixel_v, pixel_ch.zero_depth, pixel_ch.saturated};
        if (pixel_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pixel item u=%h v=%h", got.u, got.v);
        end else begin
          want = pixel_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: exp u=%h v=%h zd=%b sat=%b, got u=%h v=%h zd=%b sat=%b",
                       want.u, want.v, want.zd, want.sat, got.u, got.v, got.zd, got.sat);
          end
        end
      end
      if (cycles > CycleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Write one register and update the shadow once the write lands
  task automatic write_reg(pdp_pkg::cfg_reg_e idx, logic [63:0] data);
    cfg_idx_pend  = idx;
    cfg_data_pend = data;
    cfg_busy      = 1'b1;
    while (cfg_busy) @(posedge clk_i);
    case (idx)
      pdp_pkg::REG_FOCAL:   focal_q   = data;
      pdp_pkg::REG_CENTER:  centre_q  = data;
      pdp_pkg::REG_RADIAL1: radial1_q = data;
      pdp_pkg::REG_TANGENT: tangent_q = data;
      pdp_pkg::REG_RADIAL2: radial2_q = data;
      pdp_pkg::REG_EXTRA:   extra_q   = data;
      pdp_pkg::REG_TERMS:   terms_q   = data[3:0];
      default: ;
    endcase
  endtask

  // Wait until every point has been delivered, then let the pipeline settle
  task automatic drain_all();
    while (point_queue.size() > 0 || pixel_queue.size() > 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(3))
      0: return 32'($signed($urandom_range(0, 2097152)) - 1048576);  // small, near +-1/16
      1: return $urandom();
      2: return 32'h0;
      default: return 32'($signed($urandom_range(0, 33554432)) - 16777216);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1310720)) - 655360);   // +-10
      2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
      default: return 32'($signed($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  task automatic random_setting(int terms);
    write_reg(pdp_pkg::REG_FOCAL, {32'($urandom_range(0, 1000) << 16) | $urandom_range(65535),
                                   32'($urandom_range(0, 1000) << 16) | $urandom_range(65535)});
    write_reg(pdp_pkg::REG_CENTER,
              {$urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(1000) << 16),
               $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(1000) << 16)});
    write_reg(pdp_pkg::REG_RADIAL1, {rand_coef(), rand_coef()});
    write_reg(pdp_pkg::REG_TANGENT, {rand_coef(), rand_coef()});
    write_reg(pdp_pkg::REG_RADIAL2, {rand_coef(), rand_coef()});
    write_reg(pdp_pkg::REG_EXTRA, {rand_coef(), rand_coef()});
    write_reg(pdp_pkg::REG_TERMS, 64'(terms));
  endtask

  task automatic push_random(int count);
    point_t p;
    repeat (count) begin
      p.x = rand_coord();
      p.y = rand_coord();
      // Mostly positive depths in front of the camera, sometimes anything
      case ($urandom_range(9))
        0: p.z = $urandom();
        1: p.z = 32'h0;
        2: p.z = -32'($urandom_range(1, 1 << 20));
        default: p.z = 32'($urandom_range(1, 20 << 16));
      endcase
      point_queue.push_back(p);
    end
  endtask

  initial begin
    point_ch.valid = 1'b0;
    point_ch.point_x = '0;
    point_ch.point_y = '0;
    point_ch.point_z = '0;
    pixel_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.wdata = '0;
    cfg_busy = 1'b0;
    in_taken = 1'b0;
    cycles = 0;
    mismatches = 0;
    send_idle_pct = 14;
    recv_idle_pct = 57;
    focal_q = '0; centre_q = '0; radial1_q = '0; tangent_q = '0;
    radial2_q = '0; extra_q = '0; terms_q = pdp_pkg::TermsReset;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: plain pinhole with field extremes and zero depth, then extreme registers
    write_reg(pdp_pkg::REG_FOCAL, {32'd500 << 16, 32'd400 << 16});
    write_reg(pdp_pkg::REG_CENTER, {32'd320 << 16, 32'd240 << 16});
    for (int i = 0; i < 32; i += 4) begin
      point_queue.push_back('{32'sd1 <<< i, -(32'sd1 <<< i), 32'sd65536});
    end
    point_queue.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1});
    point_queue.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1});
    point_queue.push_back('{32'sd65536, 32'sd65536, 32'sh0});
    point_queue.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    point_queue.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    point_queue.push_back('{32'sd0, 32'sd0, -32'sd65536});
    drain_all();
    write_reg(pdp_pkg::REG_FOCAL, '1);
    write_reg(pdp_pkg::REG_CENTER, '1);
    write_reg(pdp_pkg::REG_RADIAL1, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(pdp_pkg::REG_TANGENT, {32'h8000_0000, 32'h7FFF_FFFF});
    write_reg(pdp_pkg::REG_RADIAL2, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
    write_reg(pdp_pkg::REG_EXTRA, {32'h8000_0000, 32'h8000_0000});
    write_reg(pdp_pkg::REG_TERMS, 64'(pdp_pkg::TermsK6));
    point_queue.push_back('{32'sd65536, -32'sd65536, 32'sd65536});
    point_queue.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1});
    point_queue.push_back('{32'sd100, 32'sd100, 32'sd65536});
    drain_all();
    // Counts out of range act as the nearest end; disabled coefficients must not matter
    write_reg(pdp_pkg::REG_TERMS, 64'd15);
    point_queue.push_back('{32'sd32768, 32'sd16384, 32'sd65536});
    drain_all();
    write_reg(pdp_pkg::REG_TERMS, 64'd0);
    point_queue.push_back('{32'sd32768, 32'sd16384, 32'sd65536});
    drain_all();

    // Random: phases of idling, each under a few register settings
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 14 : phase == 1 ? 57 : 0;
      recv_idle_pct = phase == 0 ? 57 : phase == 1 ? 14 : 0;
      for (int s = 0; s < 6; s++) begin
        random_setting((s == 5) ? $urandom_range(15) : 4 + ((s + phase) % 5));
        push_random(80);
        drain_all();
      end
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/pdp_pkg.sv
rtl/pdp_if.sv
rtl/pdp_qmul.sv
rtl/pdp_divider.sv
rtl/pdp_distort.sv
rtl/pinhole_distortion_projector_unit.sv
dv/pinhole_distortion_projector_unit_test.sv
